// File: design/dual_axis_light_tracker_step_assert.svh
// Assertion macros used by the light tracker checker.
`ifndef DUAL_AXIS_LIGHT_TRACKER_STEP_ASSERT_SVH
`define DUAL_AXIS_LIGHT_TRACKER_STEP_ASSERT_SVH

// Implication checked on the same edge, ignored while reset is low.
`define DALT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked on the following edge, ignored while reset is low.
`define DALT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication on the following edge that also holds across reset.
`define DALT_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/dalt_pkg.sv
// Types, constants and helper functions of the dual-axis light tracker.
package dalt_pkg;

    typedef struct packed {
        logic [11:0] light_top_left;
        logic [11:0] light_top_right;
        logic [11:0] light_bottom_left;
        logic [11:0] light_bottom_right;
        logic [4:0]  hour_of_day;
        logic [5:0]  minute_of_hour;
        logic [3:0]  month_of_year;
    } t_in_item;

    typedef struct packed {
        logic [7:0] horizontal_angle;
        logic [7:0] vertical_angle;
        logic [1:0] tracking_mode;
        logic       periodic_report;
    } t_out_item;

    typedef struct packed {
        logic [10:0] tolerance;
        logic [11:0] min_spread;
        logic [7:0]  hor_min;
        logic [7:0]  hor_max;
        logic [7:0]  ver_min;
        logic [7:0]  ver_max;
        logic        hor_invert;
        logic        ver_invert;
    } t_cfg;

    typedef enum logic [1:0] {
        SLOT_NONE = 2'd0,
        SLOT_TOP  = 2'd1,
        SLOT_HALF = 2'd2
    } t_report_slot;

    typedef struct packed {
        logic [7:0]   hor_position;
        logic [7:0]   ver_position;
        t_report_slot last_report_slot;
    } t_state;

    typedef enum logic [1:0] {
        MODE_HOLD   = 2'd0,
        MODE_TRACK  = 2'd1,
        MODE_MIDDAY = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        CFG_TOLERANCE  = 3'd0,
        CFG_MIN_SPREAD = 3'd1,
        CFG_HOR_MIN    = 3'd2,
        CFG_HOR_MAX    = 3'd3,
        CFG_VER_MIN    = 3'd4,
        CFG_VER_MAX    = 3'd5,
        CFG_HOR_INVERT = 3'd6,
        CFG_VER_INVERT = 3'd7
    } t_cfg_idx;

    localparam int CFG_DATA_W = 12;

    localparam t_cfg CFG_RESET = '{
        tolerance:  11'd5,
        min_spread: 12'd25,
        hor_min:    8'd0,
        hor_max:    8'd180,
        ver_min:    8'd10,
        ver_max:    8'd170,
        hor_invert: 1'b1,
        ver_invert: 1'b1
    };

    localparam logic [7:0] ANGLE_HOME = 8'd90;

    localparam logic [4:0] HOUR_NIGHT_START  = 5'd18;
    localparam logic [4:0] HOUR_DAY_START    = 5'd7;
    localparam logic [4:0] HOUR_MIDDAY_START = 5'd11;
    localparam logic [4:0] HOUR_MIDDAY_END   = 5'd13;

    localparam logic [5:0] MINUTE_TOP  = 6'd0;
    localparam logic [5:0] MINUTE_HALF = 6'd30;

    localparam logic [8:0] ZONE_LOW     = 9'd75;
    localparam logic [8:0] ZONE_MID     = 9'd85;
    localparam logic [8:0] ZONE_HIGH    = 9'd90;
    localparam logic [8:0] ZONE_WIDTH   = 9'd10;

    // Elevation threshold of the horizontal freeze zone by month.
    function automatic logic [8:0] zone_threshold(input logic [3:0] month);
        logic [8:0] thr;
        if (month >= 4'd11 || month <= 4'd2) begin
            thr = ZONE_LOW;
        end else if (month >= 4'd5 && month <= 4'd8) begin
            thr = ZONE_MID;
        end else begin
            thr = ZONE_HIGH;
        end
        return thr;
    endfunction

    // One-degree step: +1, -1 or 0 when the difference is inside the dead band.
    function automatic logic signed [1:0] step_dir(input logic signed [13:0] diff,
                                                   input logic [11:0] thresh2,
                                                   input logic invert);
        logic [13:0]       mag;
        logic signed [1:0] dir;
        mag = diff[13] ? 14'(-diff) : 14'(diff);
        if (mag <= {2'b00, thresh2}) begin
            dir = 2'sd0;
        end else if ((diff > 14'sd0) == invert) begin
            dir = 2'sd1;
        end else begin
            dir = -2'sd1;
        end
        return dir;
    endfunction

    // Low limit wins first, then the high limit.
    function automatic logic [7:0] clamp_angle(input logic signed [9:0] x,
                                               input logic [7:0] lo,
                                               input logic [7:0] hi);
        logic [7:0] y;
        if (x < $signed({2'b00, lo})) begin
            y = lo;
        end else if (x > $signed({2'b00, hi})) begin
            y = hi;
        end else begin
            y = x[7:0];
        end
        return y;
    endfunction

endpackage

// File: design/dalt_step_calc.sv
// Combinational next-state and result logic for one tracker item.
module dalt_step_calc
    import dalt_pkg::*;
(
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    input  t_state    i_state,
    output t_out_item o_result,
    output t_state    o_state
);

    logic [11:0]       hi_a, hi_b, lo_a, lo_b, hi_all, lo_all, spread;
    logic              night, flat, midday, hor_active;
    logic [8:0]        thr;
    logic [12:0]       sum_left, sum_right, sum_top, sum_bottom;
    logic signed [13:0] dh, dv;
    logic signed [1:0] hor_step, ver_step;
    logic signed [9:0] hor_next, ver_next;
    logic [11:0]       thresh2;
    t_mode             mode;
    logic              fire;
    t_report_slot      slot_next;

    always_comb begin
        hi_a   = (i_item.light_top_left > i_item.light_top_right) ?
                 i_item.light_top_left : i_item.light_top_right;
        hi_b   = (i_item.light_bottom_left > i_item.light_bottom_right) ?
                 i_item.light_bottom_left : i_item.light_bottom_right;
        lo_a   = (i_item.light_top_left < i_item.light_top_right) ?
                 i_item.light_top_left : i_item.light_top_right;
        lo_b   = (i_item.light_bottom_left < i_item.light_bottom_right) ?
                 i_item.light_bottom_left : i_item.light_bottom_right;
        hi_all = (hi_a > hi_b) ? hi_a : hi_b;
        lo_all = (lo_a < lo_b) ? lo_a : lo_b;
        spread = hi_all - lo_all;

        night  = (i_item.hour_of_day >= HOUR_NIGHT_START) ||
                 (i_item.hour_of_day < HOUR_DAY_START);
        flat   = spread < i_cfg.min_spread;
        midday = (i_item.hour_of_day >= HOUR_MIDDAY_START) &&
                 (i_item.hour_of_day < HOUR_MIDDAY_END);

        thr     = zone_threshold(i_item.month_of_year);
        thresh2 = {i_cfg.tolerance, 1'b0};

        sum_left   = {1'b0, i_item.light_top_left} + {1'b0, i_item.light_bottom_left};
        sum_right  = {1'b0, i_item.light_top_right} + {1'b0, i_item.light_bottom_right};
        sum_top    = {1'b0, i_item.light_top_left} + {1'b0, i_item.light_top_right};
        sum_bottom = {1'b0, i_item.light_bottom_left} + {1'b0, i_item.light_bottom_right};
        dh = $signed({1'b0, sum_left}) - $signed({1'b0, sum_right});
        dv = $signed({1'b0, sum_top}) - $signed({1'b0, sum_bottom});

        // Above the freeze zone the horizontal sense is reversed.
        hor_active = 1'b1;
        if ({1'b0, i_state.ver_position} >= thr + ZONE_WIDTH) begin
            dh = -dh;
        end else if ({1'b0, i_state.ver_position} >= thr) begin
            hor_active = 1'b0;
        end

        hor_step = (hor_active && !midday) ?
                   step_dir(dh, thresh2, i_cfg.hor_invert) : 2'sd0;
        ver_step = step_dir(dv, thresh2, i_cfg.ver_invert);
        hor_next = $signed({2'b00, i_state.hor_position}) + 10'(hor_step);
        ver_next = $signed({2'b00, i_state.ver_position}) - 10'(ver_step);

        o_state = i_state;
        if (night || flat) begin
            mode = MODE_HOLD;
        end else begin
            mode = midday ? MODE_MIDDAY : MODE_TRACK;
            o_state.hor_position = clamp_angle(hor_next, i_cfg.hor_min, i_cfg.hor_max);
            o_state.ver_position = clamp_angle(ver_next, i_cfg.ver_min, i_cfg.ver_max);
        end

        // The report fires once on arrival at the top or the half of the hour.
        fire      = 1'b0;
        slot_next = i_state.last_report_slot;
        if (i_item.minute_of_hour == MINUTE_TOP) begin
            if (i_state.last_report_slot != SLOT_TOP) begin
                fire      = 1'b1;
                slot_next = SLOT_TOP;
            end
        end else if (i_item.minute_of_hour == MINUTE_HALF) begin
            if (i_state.last_report_slot != SLOT_HALF) begin
                fire      = 1'b1;
                slot_next = SLOT_HALF;
            end
        end else begin
            slot_next = SLOT_NONE;
        end
        o_state.last_report_slot = slot_next;

        o_result.horizontal_angle = o_state.hor_position;
        o_result.vertical_angle   = o_state.ver_position;
        o_result.tracking_mode    = mode;
        o_result.periodic_report  = fire;
    end

endmodule

// File: design/dual_axis_light_tracker_step.sv
// Top level of the dual-axis light tracker: handshakes, registers and state.
//
// Dual-axis light tracker. Each input item carries four light readings, the
// hour, the minute and the month; each accepted item yields exactly one result
// item with the new horizontal and vertical servo angles, the tracking mode and
// a one-shot report flag. The block takes one item per clock cycle when the
// output side keeps up: an item is held in the input register, then the step
// logic computes the new angles from it and the current positions, and the
// result register presents the result. The positions are updated on the same
// edge that loads the result register, so the next item sees them at once. A
// full result register that is not taken stalls the input register, which
// then drops ready; nothing is lost or repeated.
// Configuration is a plain write port (enable, index, 12-bit data), each write
// masked to the register's width, and it should only be used while no item is
// in flight. Reset restores the default limits and centers both axes.
module dual_axis_light_tracker_step
    import dalt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg      r_cfg;
    t_state    r_state;
    t_state    n_state;
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;
    logic      advance;

    // The item in the input register moves on when the result slot is free or
    // is being emptied in this cycle.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    dalt_step_calc u_calc (
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .o_result (n_out),
        .o_state  (n_state)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TOLERANCE:  r_cfg.tolerance  <= i_cfg_wdata[10:0];
                CFG_MIN_SPREAD: r_cfg.min_spread <= i_cfg_wdata[11:0];
                CFG_HOR_MIN:    r_cfg.hor_min    <= i_cfg_wdata[7:0];
                CFG_HOR_MAX:    r_cfg.hor_max    <= i_cfg_wdata[7:0];
                CFG_VER_MIN:    r_cfg.ver_min    <= i_cfg_wdata[7:0];
                CFG_VER_MAX:    r_cfg.ver_max    <= i_cfg_wdata[7:0];
                CFG_HOR_INVERT: r_cfg.hor_invert <= i_cfg_wdata[0];
                CFG_VER_INVERT: r_cfg.ver_invert <= i_cfg_wdata[0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    // Tracker state follows each item as it enters the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{hor_position: ANGLE_HOME, ver_position: ANGLE_HOME,
                         last_report_slot: SLOT_NONE};
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: design/dalt_checker.sv
// Port-level checks of the light tracker, bound to its top level.
`include "dual_axis_light_tracker_step_assert.svh"

module dalt_checker
    import dalt_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // A waiting result stays put until it is taken.
    `DALT_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "result changed while stalled")

    // With the result slot empty the input side is never stalled.
    `DALT_ASSERT_IMP(a_ready_when_empty, !o_out_valid, o_in_ready, "input stalled with empty result slot")

    // The mode code never takes the unused value.
    `DALT_ASSERT_IMP(a_mode_code, o_out_valid, o_out_data.tracking_mode == MODE_HOLD || o_out_data.tracking_mode == MODE_TRACK || o_out_data.tracking_mode == MODE_MIDDAY, "bad tracking mode")

    // Reset empties the result register.
    `DALT_ASSERT_NEXT_ALWAYS(a_reset_empty, !i_rst_n, !o_out_valid, "result valid after reset")

endmodule

bind dual_axis_light_tracker_step dalt_checker u_dalt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
